>>> hw/rtl/adaptive_impedance_joint_controller_unit_macros.svh
// assertion macros for the joint controller
`ifndef ADAPTIVE_IMPEDANCE_JOINT_CONTROLLER_UNIT_MACROS_SVH
`define ADAPTIVE_IMPEDANCE_JOINT_CONTROLLER_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AIJC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define AIJC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/aijc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aijc_pkg
// shared constants and types of the adaptive impedance joint controller
// ----------------------------------------------------------------------------
package aijc_pkg;
	localparam int JOINTS = 8;
	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_MAX_K  = 3'd3;
	localparam logic [2:0] REG_ALPHA  = 3'd4;
	localparam logic [2:0] REG_ERR_G  = 3'd5;
	localparam logic [2:0] REG_INV_N  = 3'd6;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 34'sh07fffffff) r = S32_MAX;
		else if (v < -34'sh080000000) r = S32_MIN;
		return r;
	endfunction

	// request to the shared multiplier
	typedef struct packed {
		logic               go;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_req_t;
endpackage

>>> hw/rtl/adaptive_impedance_joint_controller_unit.sv
`timescale 1ns / 1ps
// sequence: with adaptation and a nonzero emg estimate a 47-step divide comes first,
// with adaptation and a zero estimate the target starts from max_k, without adaptation the adapt steps are skipped
// a new beat is taken only after the previous one has left the sequencer; ready is low while sequencing
// a result still waiting in the output register holds the sequencer in its last step
// reset: asynchronous active low; registers go to defaults, joint state clears at once
// ----------------------------------------------------------------------------
// adaptive_impedance_joint_controller_unit
// per-joint impedance law with stiffness adaptation and incremental pi update
// ----------------------------------------------------------------------------
`include "adaptive_impedance_joint_controller_unit_macros.svh"
module adaptive_impedance_joint_controller_unit import aijc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         joint_index,
	input  logic signed [31:0] meas_position,
	input  logic signed [31:0] meas_velocity,
	input  logic signed [31:0] meas_force,
	input  logic signed [31:0] set_position,
	input  logic signed [31:0] set_velocity,
	input  logic signed [31:0] set_stiffness,
	input  logic signed [31:0] set_damping,
	input  logic signed [31:0] emg_stiffness,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_joint,
	output logic signed [31:0] force_setpoint,
	output logic signed [31:0] velocity_command,
	output logic signed [31:0] stiffness_used
);
	localparam logic [4:0] ST_IDLE = 5'd0, ST_DIVW = 5'd1, ST_M1 = 5'd2, ST_M1W = 5'd3,
		ST_ADAPT = 5'd4, ST_M2 = 5'd5, ST_M2W = 5'd6, ST_SMOOTH = 5'd7, ST_KP = 5'd8,
		ST_KPW = 5'd9, ST_DV = 5'd10, ST_DVW = 5'd11, ST_FE = 5'd12, ST_GP = 5'd13,
		ST_GPW = 5'd14, ST_GI = 5'd15, ST_GIW = 5'd16, ST_GF = 5'd17, ST_GFW = 5'd18,
		ST_DONE = 5'd19;

	logic [4:0] st_q;
	logic mode_q;
	logic [30:0] gp_q, gi_q, mx_q, eg_q, inv_q;
	logic [16:0] alpha_q;
	logic signed [31:0] sk_tab_q [JOINTS];
	logic signed [31:0] pf_tab_q [JOINTS];
	logic signed [31:0] vs_tab_q [JOINTS];

	logic [2:0] jin_q;
	logic [JW-1:0] j_q;
	logic signed [31:0] mf_q, sk_q, sd_q, e_q, pe_q, ve_q;
	logic [15:0] ts_q;
	logic signed [31:0] t_q, k_q, f_q, fe_q, acc_q, gdt_q;
	logic signed [33:0] vsum_q;
	mul_req_t mreq;
	logic signed [31:0] mres;
	logic div_start, div_done;
	logic div_go_q;
	logic signed [31:0] div_q;
	logic signed [31:0] comp, tclip, alpha_c, s_cur;
	logic signed [32:0] ts_d;

	aijc_mul u_mul (.clk(clk), .req(mreq), .res(mres));
	aijc_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({inv_q, 16'd0}), .den(e_q), .done(div_done), .quo(div_q));

	assign in_ready = (st_q == ST_IDLE);
	assign div_start = div_go_q;
	assign alpha_c = alpha_q[16] ? 32'sd65536 : {16'd0, alpha_q[15:0]};
	assign s_cur = sk_tab_q[j_q];
	assign comp = sat34(34'(signed'({1'b0, mx_q})) - 34'(e_q));
	assign ts_d = {17'd0, ts_q};

	// divider kick in the cycle after the beat, once the operands are captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= (st_q == ST_IDLE) && in_valid && mode_q && (emg_stiffness != 0);
		end
	end

	// clipping chain of the target
	always_comb begin
		tclip = t_q;
		if (tclip > comp) tclip = comp;
		if (sk_q > 0) tclip = sk_q;
		if (tclip < 0) tclip = '0;
	end

	// operand select for the shared multiplier
	always_comb begin
		mreq = '0;
		unique case (st_q)
			ST_M1: begin
				mreq.go = 1'b1;
				mreq.a = 33'({1'b0, eg_q});
				mreq.b = pe_q[31] ? -33'(pe_q) : 33'(pe_q);
			end
			ST_M2: begin
				mreq.go = 1'b1;
				mreq.a = 33'(alpha_c);
				mreq.b = 33'(t_q) - 33'(s_cur);
			end
			ST_KP: begin mreq.go = 1'b1; mreq.a = 33'(k_q); mreq.b = 33'(pe_q); end
			ST_DV: begin mreq.go = 1'b1; mreq.a = 33'(sd_q); mreq.b = 33'(ve_q); end
			ST_GP: begin
				mreq.go = 1'b1;
				mreq.a = 33'({1'b0, gp_q});
				mreq.b = 33'(sat34(34'(fe_q) - 34'(pf_tab_q[j_q])));
			end
			ST_GI: begin mreq.go = 1'b1; mreq.a = 33'({1'b0, gi_q}); mreq.b = ts_d; end
			ST_GF: begin mreq.go = 1'b1; mreq.a = 33'(gdt_q); mreq.b = 33'(fe_q); end
			default: mreq = '0;
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			mode_q <= 1'b0;
			gp_q <= 31'd24248320;
			gi_q <= 31'd229376;
			mx_q <= 31'd3932160;
			alpha_q <= 17'd3277;
			eg_q <= 31'd1310720;
			inv_q <= 31'd32768000;
			for (int i = 0; i < JOINTS; i++) begin
				sk_tab_q[i] <= '0;
				pf_tab_q[i] <= '0;
				vs_tab_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[0];
						for (int i = 0; i < JOINTS; i++) begin
							sk_tab_q[i] <= '0;
							vs_tab_q[i] <= '0;
						end
					end
					REG_GAIN_P: gp_q <= cfg_data;
					REG_GAIN_I: gi_q <= cfg_data;
					REG_MAX_K:  mx_q <= cfg_data;
					REG_ALPHA:  alpha_q <= cfg_data[16:0];
					REG_ERR_G:  eg_q <= cfg_data;
					REG_INV_N:  inv_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					if (!mode_q) begin
						k_q <= set_stiffness;
						st_q <= ST_KP;
					end else if (emg_stiffness == 0) begin
						t_q <= signed'({1'b0, mx_q});
						st_q <= ST_M1;
					end else st_q <= ST_DIVW;
				end
				ST_DIVW: if (div_done) begin t_q <= div_q; st_q <= ST_M1; end
				ST_M1: st_q <= ST_M1W;
				ST_M1W: begin t_q <= sat34(34'(t_q) + 34'(mres)); st_q <= ST_ADAPT; end
				ST_ADAPT: begin t_q <= tclip; st_q <= ST_M2; end
				ST_M2: st_q <= ST_M2W;
				ST_M2W: begin
					k_q <= sat34(34'(s_cur) + 34'(mres));
					st_q <= ST_SMOOTH;
				end
				ST_SMOOTH: begin sk_tab_q[j_q] <= k_q; st_q <= ST_KP; end
				ST_KP: st_q <= ST_KPW;
				ST_KPW: begin acc_q <= mres; st_q <= ST_DV; end
				ST_DV: st_q <= ST_DVW;
				ST_DVW: begin f_q <= sat34(34'(acc_q) - 34'(mres)); st_q <= ST_FE; end
				ST_FE: begin fe_q <= sat34(34'(f_q) - 34'(mf_q)); st_q <= ST_GP; end
				ST_GP: st_q <= ST_GPW;
				ST_GPW: begin
					vsum_q <= 34'(vs_tab_q[j_q]) + 34'(mres);
					st_q <= ST_GI;
				end
				ST_GI: st_q <= ST_GIW;
				ST_GIW: begin gdt_q <= mres; st_q <= ST_GF; end
				ST_GF: st_q <= ST_GFW;
				ST_GFW: begin vsum_q <= vsum_q + 34'(mres); st_q <= ST_DONE; end
				// wait here while the previous result is still held
				ST_DONE: if (!out_valid) begin
					vs_tab_q[j_q] <= sat34(vsum_q);
					pf_tab_q[j_q] <= fe_q;
					out_joint <= jin_q;
					force_setpoint <= f_q;
					velocity_command <= sat34(vsum_q);
					stiffness_used <= k_q;
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// capture of the input beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			jin_q <= joint_index;
			j_q <= joint_index[JW-1:0];
			mf_q <= meas_force;
			sk_q <= set_stiffness;
			sd_q <= set_damping;
			e_q <= emg_stiffness;
			ts_q <= time_step;
			pe_q <= sat34(34'(set_position) - 34'(meas_position));
			ve_q <= sat34(34'(set_velocity) - 34'(meas_velocity));
		end
	end

	`AIJC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result dropped before it was taken")
	`AIJC_ASSERT_NEXT(a_done_valid, clk, arst_n, st_q == ST_DONE && !out_valid, out_valid,
		"finished item without result")
	`AIJC_ASSERT_IMP(a_busy, clk, arst_n, st_q != ST_IDLE, !in_ready,
		"ready while sequencing")
endmodule

>>> hw/rtl/aijc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aijc_mul
// shared q16.16 multiplier with round-half-up and saturation, product registered
// ----------------------------------------------------------------------------
module aijc_mul import aijc_pkg::*; (
	input  logic               clk,
	input  mul_req_t           req,
	output logic signed [31:0] res
);
	logic signed [65:0] prod_s1;
	logic signed [65:0] rnd;
	logic signed [49:0] q;

	// product register, loaded only on a request
	always_ff @(posedge clk) begin
		if (req.go) prod_s1 <= req.a * req.b;
	end

	// round, shift, saturate
	always_comb begin
		rnd = prod_s1 + 66'sd32768;
		q = rnd[65:16];
		if (q > 50'sh7fffffff) res = S32_MAX;
		else if (q < -50'sh80000000) res = S32_MIN;
		else res = q[31:0];
	end
endmodule

>>> hw/rtl/aijc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aijc_div
// radix-2 signed divider, truncating toward zero, saturated to 32 bits
// ----------------------------------------------------------------------------
module aijc_div import aijc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [46:0]        num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	logic [46:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;
	logic [47:0] mag;

	assign trial = {r_q, q_q[46]} - {2'b0, d_q};

	// shift-subtract loop, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			r_q   <= '0;
			d_q   <= den[31] ? 32'(-den) : den;
			neg_q <= den[31];
		end else if (busy_q) begin
			if (!trial[33]) begin
				r_q <= trial[32:0];
				q_q <= {q_q[45:0], 1'b1};
			end else begin
				r_q <= {r_q[31:0], q_q[46]};
				q_q <= {q_q[45:0], 1'b0};
			end
		end
	end

	// sign and saturate
	always_comb begin
		mag = {1'b0, q_q};
		if (neg_q) begin
			if (mag > 48'h80000000) quo = S32_MIN;
			else quo = 32'(-mag);
		end else begin
			if (mag > 48'h7fffffff) quo = S32_MAX;
			else quo = mag[31:0];
		end
	end
endmodule

>>> tb/tb_adaptive_impedance_joint_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_impedance_joint_controller_unit
// self-checking bench: a queue-fed driver offers control steps and register
// writes, a clocked monitor predicts each step's force, velocity and
// stiffness and compares every result beat against the oldest prediction
// ----------------------------------------------------------------------------
module tb_adaptive_impedance_joint_controller_unit;
	import aijc_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic        is_cfg;
		logic [2:0]  idx;
		logic [30:0] data;
		logic [2:0]  joint;
		logic signed [31:0] mp, mv, mf, sp, sv, sk, sd, emg;
		logic [15:0] ts;
	} step_t;

	typedef struct {
		logic [2:0]         joint;
		logic signed [31:0] force_sp;
		logic signed [31:0] vel_cmd;
		logic signed [31:0] k_used;
	} control_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         joint_index = '0;
	logic signed [31:0] meas_position = '0, meas_velocity = '0, meas_force = '0;
	logic signed [31:0] set_position = '0, set_velocity = '0, set_stiffness = '0;
	logic signed [31:0] set_damping = '0, emg_stiffness = '0;
	logic [15:0]        time_step = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         out_joint;
	logic signed [31:0] force_setpoint, velocity_command, stiffness_used;

	adaptive_impedance_joint_controller_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.joint_index(joint_index), .meas_position(meas_position),
		.meas_velocity(meas_velocity), .meas_force(meas_force),
		.set_position(set_position), .set_velocity(set_velocity),
		.set_stiffness(set_stiffness), .set_damping(set_damping),
		.emg_stiffness(emg_stiffness), .time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready), .out_joint(out_joint),
		.force_setpoint(force_setpoint), .velocity_command(velocity_command),
		.stiffness_used(stiffness_used)
	);

	step_t    pending_steps[$];
	control_t expected_controls[$];
	int       errors = 0;
	logic     in_fire = 1'b0;
	logic     stim_done = 1'b0;
	int       burst_left = 0, gap_left = 0, settle_cnt = 0;
	int       hold_left = 0, rx_phase_left = 0, rx_stall_pct = 0;
	int       results_seen = 0, idle_cycles = 0;
	logic     long_hold_done = 1'b0;

	// controller model state and registers
	logic        m_mode;
	longint      m_gain_p, m_gain_i, m_max_k, m_alpha, m_err_g, m_inv_n;
	longint      m_smooth_k[JOINTS];
	longint      m_prev_fe[JOINTS];
	longint      m_vel_sp[JOINTS];

	initial forever #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// q16.16 product, round half up, saturated
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b + 32768) >>> 16);
	endfunction

	function automatic void reset_model();
		m_mode = 1'b0;
		m_gain_p = 24248320; m_gain_i = 229376; m_max_k = 3932160;
		m_alpha = 3277; m_err_g = 1310720; m_inv_n = 32768000;
		for (int j = 0; j < JOINTS; j++) begin
			m_smooth_k[j] = 0; m_prev_fe[j] = 0; m_vel_sp[j] = 0;
		end
	endfunction

	function automatic void write_model_reg(logic [2:0] idx, logic [30:0] d);
		case (idx)
			REG_MODE: begin
				m_mode = d[0];
				for (int j = 0; j < JOINTS; j++) begin
					m_smooth_k[j] = 0; m_vel_sp[j] = 0;
				end
			end
			REG_GAIN_P: m_gain_p = longint'(d);
			REG_GAIN_I: m_gain_i = longint'(d);
			REG_MAX_K:  m_max_k = longint'(d);
			REG_ALPHA:  m_alpha = longint'(d[16:0]);
			REG_ERR_G:  m_err_g = longint'(d);
			REG_INV_N:  m_inv_n = longint'(d);
			default: ;
		endcase
	endfunction

	function automatic control_t control_step(step_t s);
		control_t r;
		int j;
		longint pe, ve, k, f, fe, gdt, vs, t, lim, a, e;
		j = s.joint % JOINTS;
		pe = clamp32(longint'(s.sp) - longint'(s.mp));
		ve = clamp32(longint'(s.sv) - longint'(s.mv));
		e = longint'(s.emg);
		if (m_mode) begin
			// adapted stiffness target, then exponential smoothing
			if (e == 0) t = m_max_k;
			else t = clamp32((m_inv_n * 65536) / e);
			t = clamp32(t + qmul(m_err_g, (pe < 0) ? -pe : pe));
			lim = clamp32(m_max_k - e);
			if (t > lim) t = lim;
			if (s.sk > 0) t = longint'(s.sk);
			if (t < 0) t = 0;
			a = (m_alpha > 65536) ? 65536 : m_alpha;
			m_smooth_k[j] = clamp32(m_smooth_k[j] + ((a * (t - m_smooth_k[j]) + 32768) >>> 16));
			k = m_smooth_k[j];
		end else begin
			k = longint'(s.sk);
		end
		// impedance law and incremental pi
		f = clamp32(qmul(k, pe) - qmul(longint'(s.sd), ve));
		fe = clamp32(f - longint'(s.mf));
		gdt = qmul(m_gain_i, longint'(s.ts));
		vs = clamp32(m_vel_sp[j] + qmul(m_gain_p, clamp32(fe - m_prev_fe[j])) + qmul(gdt, fe));
		m_vel_sp[j] = vs;
		m_prev_fe[j] = fe;
		r.joint = s.joint;
		r.force_sp = f[31:0];
		r.vel_cmd = vs[31:0];
		r.k_used = k[31:0];
		return r;
	endfunction

	// mix of full range, small q16.16 values, extremes and zero
	function automatic logic signed [31:0] pick_q();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2, 3: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			4: return ($urandom_range(0, 1)) ? S32_MAX : S32_MIN;
			default: return ($urandom_range(0, 1)) ? 32'sd0 : 32'sd65536;
		endcase
	endfunction

	function automatic step_t rand_step();
		step_t s;
		s.is_cfg = 1'b0; s.idx = '0; s.data = '0;
		s.joint = 3'($urandom_range(0, 7));
		s.mp = pick_q(); s.mv = pick_q(); s.mf = pick_q(); s.sp = pick_q();
		s.sv = pick_q(); s.sd = pick_q(); s.emg = pick_q(); s.ts = 16'($urandom);
		s.sk = ($urandom_range(0, 2) == 0) ? pick_q() :
			-$signed(32'($urandom_range(0, 1000)));
		return s;
	endfunction

	function automatic step_t dir_step(logic [2:0] j, logic signed [31:0] v,
			logic signed [31:0] sk, logic signed [31:0] emg, logic [15:0] ts);
		step_t s;
		s.is_cfg = 1'b0; s.idx = '0; s.data = '0;
		s.joint = j; s.mp = -v; s.mv = v; s.mf = v; s.sp = v; s.sv = -v;
		s.sk = sk; s.sd = v; s.emg = emg; s.ts = ts;
		return s;
	endfunction

	task automatic push_cfg(logic [2:0] idx, int unsigned d);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1; s.idx = idx; s.data = 31'(d);
		pending_steps.push_back(s);
	endtask

	// stimulus plan and end of run
	initial begin
		int unsigned big;
		big = 32'h7fffffff;
		reset_model();
		// directed: extremes, emg zero and negative, override, all joints
		for (int unsigned m = 0; m < 2; m++) begin
			push_cfg(REG_MODE, m);
			pending_steps.push_back(dir_step(3'd0, S32_MAX, S32_MAX, 0, 16'hffff));
			pending_steps.push_back(dir_step(3'd1, S32_MIN, S32_MIN, S32_MIN, 16'h0000));
			pending_steps.push_back(dir_step(3'd2, 32'sd65536, 0, 0, 16'd655));
			pending_steps.push_back(dir_step(3'd3, -32'sd65536, -32'sd5, -32'sd65536, 16'd100));
			pending_steps.push_back(dir_step(3'd4, 32'sd1000, 32'sd131072, 32'sd131072, 16'd1));
			pending_steps.push_back(dir_step(3'd5, 32'sd0, 0, S32_MAX, 16'h8000));
			pending_steps.push_back(dir_step(3'd6, -32'sd3, 32'sd1, 32'sd1, 16'h7fff));
			pending_steps.push_back(dir_step(3'd7, S32_MAX, 0, -32'sd1, 16'hffff));
			pending_steps.push_back(dir_step(3'd7, 32'sd12345, -32'sd1, 32'sd70000, 16'd10));
		end
		// random phases over several register settings
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: push_cfg(REG_MODE, 0);
				1: begin push_cfg(REG_MODE, 1); push_cfg(REG_UNUSED, big); end
				2: begin
					push_cfg(REG_GAIN_P, 0); push_cfg(REG_GAIN_I, 0); push_cfg(REG_MAX_K, 0);
					push_cfg(REG_ALPHA, 0); push_cfg(REG_ERR_G, 0); push_cfg(REG_INV_N, 0);
				end
				3: begin
					push_cfg(REG_GAIN_P, big); push_cfg(REG_GAIN_I, big); push_cfg(REG_MAX_K, big);
					push_cfg(REG_ALPHA, 65536); push_cfg(REG_ERR_G, big); push_cfg(REG_INV_N, big);
				end
				4: begin push_cfg(REG_ALPHA, 32'h0001ffff); push_cfg(REG_MODE, 1); end
				5: begin push_cfg(REG_MODE, 0); push_cfg(REG_GAIN_P, 65536); end
				default: begin
					push_cfg(REG_GAIN_P, $urandom_range(0, 32'h0100_0000));
					push_cfg(REG_GAIN_I, $urandom_range(0, 32'h0010_0000));
					push_cfg(REG_MAX_K, $urandom & big);
					push_cfg(REG_ALPHA, $urandom_range(0, 65536));
					push_cfg(REG_ERR_G, $urandom_range(0, 32'h0040_0000));
					push_cfg(REG_INV_N, $urandom & big);
					push_cfg(REG_MODE, $urandom_range(0, 1));
				end
			endcase
			for (int i = 0; i < 108; i++) pending_steps.push_back(rand_step());
		end
		repeat (6) @(posedge clk);
		arst_n = 1'b1;
		wait (stim_done && expected_controls.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_controls.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// driver: bursts of beats with random gaps, register writes only when idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_fire)) begin
			if (cfg_we) begin
				cfg_we <= 1'b0;
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_steps.size() == 0) begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end else if (pending_steps[0].is_cfg) begin
				in_valid <= 1'b0;
				if (expected_controls.size() != 0 || in_valid) begin
					settle_cnt <= 0;
				end else if (settle_cnt < SETTLE_CYCLES) begin
					settle_cnt <= settle_cnt + 1;
				end else begin
					settle_cnt <= 0;
					cfg_we <= 1'b1;
					cfg_index <= pending_steps[0].idx;
					cfg_data <= pending_steps[0].data;
					write_model_reg(pending_steps[0].idx, pending_steps[0].data);
					void'(pending_steps.pop_front());
				end
			end else begin
				joint_index <= pending_steps[0].joint;
				meas_position <= pending_steps[0].mp;
				meas_velocity <= pending_steps[0].mv;
				meas_force <= pending_steps[0].mf;
				set_position <= pending_steps[0].sp;
				set_velocity <= pending_steps[0].sv;
				set_stiffness <= pending_steps[0].sk;
				set_damping <= pending_steps[0].sd;
				emg_stiffness <= pending_steps[0].emg;
				time_step <= pending_steps[0].ts;
				in_valid <= 1'b1;
				void'(pending_steps.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: stall pattern of its own plus one long hold-off
	always @(negedge clk) begin
		if (!long_hold_done && results_seen >= 300) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_phase_left <= $urandom_range(10, 200);
				case ($urandom_range(0, 2))
					0: rx_stall_pct <= 0;
					1: rx_stall_pct <= 30;
					default: rx_stall_pct <= 85;
				endcase
			end else begin
				rx_phase_left <= rx_phase_left - 1;
			end
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// monitor: predict on input beats, check output beats, watchdog
	always @(posedge clk) begin
		control_t want;
		step_t s;
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			s.is_cfg = 1'b0; s.idx = '0; s.data = '0;
			s.joint = joint_index; s.mp = meas_position; s.mv = meas_velocity;
			s.mf = meas_force; s.sp = set_position; s.sv = set_velocity;
			s.sk = set_stiffness; s.sd = set_damping; s.emg = emg_stiffness;
			s.ts = time_step;
			expected_controls.push_back(control_step(s));
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_controls.size() == 0) begin
				errors = errors + 1;
				$display("%0t unexpected result beat: joint %0d", $time, out_joint);
			end else begin
				want = expected_controls.pop_front();
				if (out_joint !== want.joint) begin
					errors = errors + 1;
					$display("%0t out_joint exp %0d got %0d", $time, want.joint, out_joint);
				end
				if (force_setpoint !== want.force_sp) begin
					errors = errors + 1;
					$display("%0t force_setpoint exp %0d got %0d", $time, want.force_sp,
						force_setpoint);
				end
				if (velocity_command !== want.vel_cmd) begin
					errors = errors + 1;
					$display("%0t velocity_command exp %0d got %0d", $time, want.vel_cmd,
						velocity_command);
				end
				if (stiffness_used !== want.k_used) begin
					errors = errors + 1;
					$display("%0t stiffness_used exp %0d got %0d", $time, want.k_used,
						stiffness_used);
				end
			end
		end
		if (!arst_n || in_fire || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end
endmodule

>>> adaptive_impedance_joint_controller_unit.f
+incdir+hw/rtl
hw/rtl/aijc_pkg.sv
hw/rtl/aijc_mul.sv
hw/rtl/aijc_div.sv
hw/rtl/adaptive_impedance_joint_controller_unit.sv
tb/tb_adaptive_impedance_joint_controller_unit.sv
